@@ rtl/core/csvt_pkg.sv @@
// Shared types and character codes for the CSV cell tokenizer.
// Used by csvt_decode, csvt_emit, csv_cell_tokenizer and its checker; no dependencies.
`default_nettype none

package csvt_pkg;

  // Character codes that steer the tokenizer.
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_SEMI  = 8'h3B;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;

  // Result kinds.
  localparam logic [1:0] KIND_BYTE = 2'd0;
  localparam logic [1:0] KIND_CELL = 2'd1;
  localparam logic [1:0] KIND_ROW  = 2'd2;
  localparam logic [1:0] KIND_END  = 2'd3;

  // Most results one input byte can cause.
  localparam int unsigned MAX_RES = 3;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       is_final;
  } in_word_t;

  typedef struct packed {
    logic [1:0] out_kind;
    logic [7:0] out_byte;
    logic       run_last;
  } out_word_t;

  typedef struct packed {
    logic inside_quotes;
    logic quote_pending;
    logic cr_pending;
    logic cell_has_data;
    logic row_has_cells;
  } tok_state_t;

  // Everything one decoded byte produces: its results, how many, and the new state.
  typedef struct packed {
    logic [1:0]                 cnt;
    out_word_t [MAX_RES-1:0]    res;
    tok_state_t                 st_nxt;
  } dec_t;

endpackage

`default_nettype wire

@@ rtl/core/csvt_decode.sv @@
// Combinational decode of one text byte against the tokenizer state.
// Depends on csvt_pkg.
`default_nettype none

module csvt_decode (
  input  wire csvt_pkg::tok_state_t st_in,
  input  wire csvt_pkg::in_word_t   word,
  output csvt_pkg::dec_t            dec
);

  always_comb begin
    csvt_pkg::tok_state_t st;
    logic [1:0] n;
    logic       used;
    logic [7:0] c;
    st   = st_in;
    n    = 2'd0;
    used = 1'b0;
    c    = word.data_byte;
    dec  = '0;

    // An LF straight after a row-ending CR belongs to that row end.
    if (st.cr_pending) begin
      st.cr_pending = 1'b0;
      if (c == csvt_pkg::CH_LF) begin
        used = 1'b1;
      end
    end

    // A quote inside quotes is resolved by the byte that follows it.
    if (!used && st.quote_pending) begin
      st.quote_pending = 1'b0;
      if (c == csvt_pkg::CH_QUOTE) begin
        dec.res[n] = '{out_kind: csvt_pkg::KIND_BYTE, out_byte: csvt_pkg::CH_QUOTE,
                       run_last: 1'b0};
        n = n + 2'd1;
        st.cell_has_data = 1'b1;
        used = 1'b1;
      end else begin
        st.inside_quotes = 1'b0;
      end
    end

    if (!used) begin
      if (st.inside_quotes) begin
        if (c == csvt_pkg::CH_QUOTE) begin
          st.quote_pending = 1'b1;
        end else begin
          dec.res[n] = '{out_kind: csvt_pkg::KIND_BYTE, out_byte: c, run_last: 1'b0};
          n = n + 2'd1;
          st.cell_has_data = 1'b1;
        end
      end else if (c == csvt_pkg::CH_QUOTE && !st.cell_has_data) begin
        st.inside_quotes = 1'b1;
      end else if (c == csvt_pkg::CH_COMMA || c == csvt_pkg::CH_SEMI ||
                   c == csvt_pkg::CH_TAB) begin
        dec.res[n] = '{out_kind: csvt_pkg::KIND_CELL, out_byte: 8'h00, run_last: 1'b0};
        n = n + 2'd1;
        st.row_has_cells = 1'b1;
        st.cell_has_data = 1'b0;
      end else if (c == csvt_pkg::CH_LF || c == csvt_pkg::CH_CR) begin
        dec.res[n] = '{out_kind: csvt_pkg::KIND_ROW, out_byte: 8'h00, run_last: 1'b0};
        n = n + 2'd1;
        st.cell_has_data = 1'b0;
        st.row_has_cells = 1'b0;
        st.cr_pending    = (c == csvt_pkg::CH_CR);
      end else begin
        dec.res[n] = '{out_kind: csvt_pkg::KIND_BYTE, out_byte: c, run_last: 1'b0};
        n = n + 2'd1;
        st.cell_has_data = 1'b1;
      end
    end

    // The final byte closes any open row and ends the stream.
    if (word.is_final) begin
      if (st.cell_has_data || st.row_has_cells) begin
        dec.res[n] = '{out_kind: csvt_pkg::KIND_ROW, out_byte: 8'h00, run_last: 1'b0};
        n = n + 2'd1;
      end
      dec.res[n] = '{out_kind: csvt_pkg::KIND_END, out_byte: 8'h00, run_last: 1'b0};
      n = n + 2'd1;
      st = '0;
    end

    if (n != 2'd0) begin
      dec.res[n - 2'd1].run_last = 1'b1;
    end

    dec.cnt    = n;
    dec.st_nxt = st;
  end

endmodule

`default_nettype wire

@@ rtl/core/csvt_emit.sv @@
// Result buffer: holds a decoded byte's results; hands one out per cycle unless stalled.
// Depends on csvt_pkg.
`default_nettype none

module csvt_emit (
  input  wire                      clk,
  input  wire                      rst_n,
  input  wire                      load,
  input  wire csvt_pkg::dec_t      dec,
  output logic                     free,
  output logic                     out_valid,
  input  wire                      out_stall,
  output csvt_pkg::out_word_t      out_data
);

  csvt_pkg::out_word_t [csvt_pkg::MAX_RES-1:0] slot_r, slot_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       pop;

  assign pop  = (cnt_r != 2'd0) && !out_stall;
  // The buffer can take a new set once it is empty or its last word leaves the port.
  assign free = (cnt_r == 2'd0) || ((cnt_r == 2'd1) && pop);

  always_comb begin
    slot_nxt = slot_r;
    cnt_nxt  = cnt_r;
    if (load) begin
      slot_nxt = dec.res;
      cnt_nxt  = dec.cnt;
    end else if (pop) begin
      slot_nxt[0] = slot_r[1];
      slot_nxt[1] = slot_r[2];
      cnt_nxt     = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
    end
    slot_r <= slot_nxt;
  end

  assign out_valid = (cnt_r != 2'd0);
  assign out_data  = slot_r[0];

endmodule

`default_nettype wire

@@ rtl/core/csv_cell_tokenizer.sv @@
// Top level of the CSV cell tokenizer: input register, tokenizer state and result buffer.
// Depends on csvt_pkg, csvt_decode and csvt_emit.
//
// Usage. Text enters on the input channel one word per cycle while in_stall is
// low: a byte and a flag marking the last byte of the text. Results leave on
// the output channel one word per cycle while out_stall is low: a content
// byte, an end of cell, an end of cell and row, or an end of stream, with
// run_last set on the last result that a given byte causes. Comma, semicolon
// and tab separate cells; CR, LF or CR LF end a row; quotes open a quoted cell
// only at its start. Each byte passes through the input register and then the
// result buffer. Throughput: one byte per cycle while each byte gives at most
// one result and nothing stalls; a byte that gives more holds the input until
// its results but the last have left, because the result buffer hands out one
// word per cycle. A byte that gives no result (an LF after a CR, an opening
// quote) does not slow the input. When the receiver stalls, the result on the
// port holds and the input register fills, after which in_stall rises. After
// the final byte the state returns to its reset value, so the next byte starts
// a new text. Reset empties the input register and the result buffer and clears
// the tokenizer state; it takes effect at the first clock edge with rst_n low.
`default_nettype none

module csv_cell_tokenizer (
  input  wire                      clk,
  input  wire                      rst_n,
  input  wire                      in_valid,
  output logic                     in_stall,
  input  wire csvt_pkg::in_word_t  in_data,
  output logic                     out_valid,
  input  wire                      out_stall,
  output csvt_pkg::out_word_t      out_data
);

  csvt_pkg::in_word_t   in_r;
  logic                 in_vld_r, in_vld_nxt;
  csvt_pkg::tok_state_t st_r, st_nxt;
  csvt_pkg::dec_t       dec;
  logic                 free;
  logic                 load;
  logic                 accept;

  // The held byte is decoded and moved into the result buffer as soon as the
  // buffer will be empty; the state advances at the same edge.
  assign load     = in_vld_r && free;
  assign in_stall = in_vld_r && !load;
  assign accept   = in_valid && !in_stall;

  assign in_vld_nxt = accept || (in_vld_r && !load);
  assign st_nxt     = load ? dec.st_nxt : st_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
      st_r     <= '0;
    end else begin
      in_vld_r <= in_vld_nxt;
      st_r     <= st_nxt;
    end
    if (accept) begin
      in_r <= in_data;
    end
  end

  csvt_decode u_decode (
    .st_in (st_r),
    .word  (in_r),
    .dec   (dec)
  );

  csvt_emit u_emit (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (load),
    .dec       (dec),
    .free      (free),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

@@ rtl/core/csvt_checker.sv @@
// Port-level checks for the CSV cell tokenizer, bound to its top level.
// Depends on csvt_pkg and csv_cell_tokenizer.
`default_nettype none

module csvt_checker (
  input wire                      clk,
  input wire                      rst_n,
  input wire                      in_stall,
  input wire                      out_valid,
  input wire                      out_stall,
  input wire csvt_pkg::out_word_t out_data
);

  // A stalled result stays on the port unchanged.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  // Nothing is offered in the cycle after reset.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result offered after reset");

  // The input only backs up behind a waiting result.
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid)
    else $error("input stalled with no result pending");

  // End of stream is always the last result of its byte.
  a_end_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.out_kind == csvt_pkg::KIND_END |-> out_data.run_last)
    else $error("end of stream without run_last");

  // Markers carry a zero byte.
  a_marker_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.out_kind != csvt_pkg::KIND_BYTE |-> out_data.out_byte == 8'h00)
    else $error("marker with non-zero byte");

endmodule

bind csv_cell_tokenizer csvt_checker u_csvt_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

`default_nettype wire
